/* design/gnac_pkg.sv */
package gnac_pkg;

    localparam int COORD_W = 24;
    localparam int VAL_W   = 20;
    localparam int COLOR_W = 8;
    localparam int BOUND_W = 25;
    localparam int DIST_W  = 51;

    localparam logic [DIST_W-1:0] LIMIT_SQ  = 51'd104857600000000;
    localparam logic [20:0]       DIV7_MUL  = 21'd1198373;
    localparam int                DIV7_SHIFT = 23;
    localparam logic signed [20:0] ONE_Q12  = 21'sd4096;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_BUILD = 2'd2,
        OP_QUERY = 2'd3
    } op_t;

    typedef struct packed {
        op_t                        op;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic signed [COORD_W-1:0]  z;
        logic signed [VAL_W-1:0]    val;
    } cmd_t;

    typedef struct packed {
        logic [COLOR_W-1:0] r;
        logic [COLOR_W-1:0] g;
        logic [COLOR_W-1:0] b;
    } rgb_t;

    function automatic logic [COLOR_W-1:0] chan(input logic signed [20:0] c);
        logic [12:0] cc;
        logic [20:0] p;
        begin
            if (c < 0)
                cc = 13'd0;
            else if (c > ONE_Q12)
                cc = 13'd4096;
            else
                cc = c[12:0];
            p = 21'(cc) * 21'd255 + 21'd2048;
            chan = p[19:12];
        end
    endfunction

    function automatic rgb_t color_of(input logic signed [VAL_W-1:0] v);
        rgb_t o;
        logic signed [20:0] ve;
        begin
            ve = 21'(v);
            if (v < 0)
            begin
                o.b = 8'd255;
                o.r = chan(ONE_Q12 + ve);
                o.g = o.r;
            end
            else if (v > 0)
            begin
                o.r = 8'd255;
                o.g = chan(ONE_Q12 - ve);
                o.b = o.g;
            end
            else
            begin
                o.r = 8'd255;
                o.g = 8'd255;
                o.b = 8'd255;
            end
            color_of = o;
        end
    endfunction

endpackage

/* design/gnac_cmd_if.sv */
interface gnac_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic signed [23:0] coord_x;
    logic signed [23:0] coord_y;
    logic signed [23:0] coord_z;
    logic signed [19:0] atom_value;

    modport source(output valid, opcode, coord_x, coord_y, coord_z, atom_value, input ready);
    modport sink(input valid, opcode, coord_x, coord_y, coord_z, atom_value, output ready);
endinterface

/* design/gnac_res_if.sv */
interface gnac_res_if;
    logic               valid;
    logic               ready;
    logic               status;
    logic signed [19:0] nearest_value;
    logic [7:0]         color_red;
    logic [7:0]         color_green;
    logic [7:0]         color_blue;

    modport source(output valid, status, nearest_value, color_red, color_green, color_blue,
                   input ready);
    modport sink(input valid, status, nearest_value, color_red, color_green, color_blue,
                 output ready);
endinterface

/* design/gnac_front.sv */
module gnac_front (
    input  logic           clk,
    input  logic           rst_n,
    gnac_cmd_if.sink       cmd,
    output logic           q_valid,
    output gnac_pkg::cmd_t q_cmd,
    input  logic           q_pop
);
    import gnac_pkg::*;

    cmd_t       ent_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       push;
    cmd_t       beat;

    assign cmd.ready = (cnt_reg != 2'd2);
    assign push      = cmd.valid && cmd.ready;
    assign q_valid   = (cnt_reg != 2'd0);
    assign q_cmd     = ent_reg[rp_reg];

    // classify the beat
    always_comb
    begin
        beat.op  = op_t'(cmd.opcode);
        beat.x   = cmd.coord_x;
        beat.y   = cmd.coord_y;
        beat.z   = cmd.coord_z;
        beat.val = cmd.atom_value;
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !q_pop)
            cnt_next = cnt_reg + 2'd1;
        else if (!push && q_pop)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wp_reg <= ~wp_reg;
            if (q_pop)
                rp_reg <= ~rp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            ent_reg[wp_reg] <= beat;
    end

endmodule

/* design/gnac_div.sv */
module gnac_div #(
    parameter int NW = 29,
    parameter int DW = 26
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [NW-1:0] quo,
    output logic          done
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] quo_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] den_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [DW:0]   rem_sh;
    logic          fits;

    assign rem_sh = {rem_reg, quo_reg[NW-1]};
    assign fits   = (rem_sh >= {1'b0, den_reg});
    assign quo    = quo_reg;
    assign done   = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CW'(NW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= DW'(rem_sh - {1'b0, den_reg});
                quo_reg <= {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[DW-1:0];
                quo_reg <= {quo_reg[NW-2:0], 1'b0};
            end
        end
    end

endmodule

/* design/gnac_back.sv */
module gnac_back #(
    parameter int MAX_ATOMS      = 1024,
    parameter int CELLS_PER_AXIS = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  gnac_pkg::cmd_t q_cmd,
    output logic           q_pop,
    gnac_res_if.source     res
);
    import gnac_pkg::*;

    localparam int AW     = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
    localparam int CNTW   = $clog2(MAX_ATOMS + 1);
    localparam int C      = CELLS_PER_AXIS;
    localparam int XW     = $clog2(C);
    localparam int NCELLS = C * C * C;
    localparam int CIDW   = $clog2(NCELLS);
    localparam int CELLW  = $clog2(NCELLS + 1);
    localparam int DW     = BOUND_W + 1;
    localparam int NW     = BOUND_W + 1 + XW;
    localparam int IW     = XW + 3;

    typedef enum logic [4:0] {
        S_IDLE, S_LOAD, S_FIN,
        S_BOX_RD, S_BOX_ACC, S_BOUND, S_ZERO,
        S_CNT_RD, S_CNT_DIV, S_CNT_WAIT, S_CNT_INC,
        S_PRE_RD, S_PRE_WR, S_PL_RD, S_PL_CUR, S_PL_WR,
        S_Q_DIV, S_Q_C0, S_Q_C1, S_Q_C2, S_Q_S0, S_Q_S1, S_Q_S2, S_Q_S3
    } state_t;

    state_t state_reg;

    // control and bookkeeping
    logic [CNTW-1:0]           total_reg;
    logic                      ready_reg;
    logic signed [BOUND_W-1:0] lo_reg [3];
    logic signed [BOUND_W-1:0] hi_reg [3];
    logic [DW-1:0]             span_reg [3];
    logic signed [COORD_W-1:0] mn_reg [3];
    logic signed [COORD_W-1:0] mx_reg [3];
    logic [CNTW-1:0]           idx_reg;
    logic [CELLW-1:0]          cc_reg;
    logic [CNTW-1:0]           run_reg;
    logic [CIDW-1:0]           cell_reg;
    logic [XW-1:0]             x_reg, y_reg, z_reg;
    logic [XW-1:0]             ys_reg, zs_reg;
    logic [XW-1:0]             xe_reg, ye_reg, ze_reg;
    logic [CNTW-1:0]           slot_reg;
    logic [CNTW-1:0]           slot_end_reg;
    logic [DIST_W-1:0]         bestd_reg;
    logic signed [VAL_W-1:0]   bestv_reg;
    logic                      status_reg;
    logic [49:0]               sq_reg [3];
    logic signed [VAL_W-1:0]   cand_reg;
    logic                      neg_reg [3];
    cmd_t                      cmd_reg;
    logic                      out_valid_reg;
    logic                      out_status_reg;
    logic signed [VAL_W-1:0]   out_value_reg;
    rgb_t                      out_rgb_reg;

    // memories
    logic signed [COORD_W-1:0] posx_mem [MAX_ATOMS];
    logic signed [COORD_W-1:0] posy_mem [MAX_ATOMS];
    logic signed [COORD_W-1:0] posz_mem [MAX_ATOMS];
    logic signed [VAL_W-1:0]   val_mem  [MAX_ATOMS];
    logic [CIDW-1:0]           acell_mem [MAX_ATOMS];
    logic [CNTW-1:0]           cnt_mem  [NCELLS];
    logic [CNTW-1:0]           first_mem [NCELLS + 1];
    logic [AW-1:0]             ord_mem  [MAX_ATOMS];

    logic signed [COORD_W-1:0] pos_rd [3];
    logic signed [VAL_W-1:0]   val_rd;
    logic [CIDW-1:0]           acell_rd;
    logic [CNTW-1:0]           cnt_rd;
    logic [CNTW-1:0]           first_rd;
    logic [AW-1:0]             ord_rd;

    logic [AW-1:0]    pos_raddr;
    logic             pos_we;
    logic             acell_we;
    logic             cnt_we;
    logic [CIDW-1:0]  cnt_waddr;
    logic [CNTW-1:0]  cnt_wdata;
    logic [CIDW-1:0]  cnt_raddr;
    logic             first_we;
    logic [CELLW-1:0] first_waddr;
    logic [CELLW-1:0] first_raddr;
    logic             ord_we;

    // dividers and derived values
    logic                      div_start;
    logic signed [COORD_W-1:0] p_sel [3];
    logic [NW-1:0]             mag [3];
    logic                      nsign [3];
    logic [NW-1:0]             quo [3];
    logic [2:0]                div_done;
    logic signed [IW-1:0]      qi [3];
    logic [XW-1:0]             clampi [3];
    logic [XW-1:0]             rs [3];
    logic [XW-1:0]             re [3];
    logic [2:0]                rempty;
    logic [CIDW-1:0]           cell_new;
    logic [CIDW-1:0]           cell_cur;
    logic [40:0]               d7_prod;
    logic [19:0]               d7_mag;
    logic [19:0]               d7_q;
    logic signed [VAL_W-1:0]   scaled;
    logic [DIST_W-1:0]         d2;

    function automatic logic [CIDW-1:0] cell_of(input logic [XW-1:0] a, input logic [XW-1:0] b,
                                                input logic [XW-1:0] c);
        cell_of = CIDW'((int'(a) * C + int'(b)) * C + int'(c));
    endfunction

    // divide by seven, truncated toward zero
    always_comb
    begin
        d7_mag  = cmd_reg.val[VAL_W-1] ? 20'(-cmd_reg.val) : 20'(cmd_reg.val);
        d7_prod = 41'(d7_mag) * 41'(DIV7_MUL);
        d7_q    = d7_prod[DIV7_SHIFT +: 20];
        scaled  = cmd_reg.val[VAL_W-1] ? VAL_W'(-d7_q) : VAL_W'(d7_q);
    end

    genvar k;
    generate
        for (k = 0; k < 3; k++)
        begin : g_axis
            logic signed [BOUND_W:0] diff;
            logic signed [NW-1:0]    numer;

            always_comb
            begin
                diff  = BOUND_W'(p_sel[k]) - lo_reg[k];
                numer = $signed(NW'(diff)) * $signed(NW'(C));
                nsign[k] = numer[NW-1];
                mag[k]   = numer[NW-1] ? NW'(-numer) : NW'(numer);
            end

            gnac_div #(.NW(NW), .DW(DW)) u_div (
                .clk   (clk),
                .rst_n (rst_n),
                .start (div_start),
                .num   (mag[k]),
                .den   (span_reg[k]),
                .quo   (quo[k]),
                .done  (div_done[k])
            );

            always_comb
            begin
                if (neg_reg[k])
                begin
                    if (quo[k] == '0)
                        qi[k] = '0;
                    else if (quo[k] == NW'(1))
                        qi[k] = -IW'(1);
                    else
                        qi[k] = -IW'(2);
                end
                else if (quo[k] > NW'(C + 1))
                    qi[k] = IW'(C + 1);
                else
                    qi[k] = IW'(quo[k]);

                if (qi[k] < 0)
                    clampi[k] = '0;
                else if (qi[k] > IW'(C - 1))
                    clampi[k] = XW'(C - 1);
                else
                    clampi[k] = XW'(qi[k]);

                rempty[k] = (qi[k] < -IW'(1)) || (qi[k] > IW'(C));
                rs[k] = (qi[k] >= IW'(1)) ? XW'(qi[k] - IW'(1)) : '0;
                re[k] = (qi[k] + IW'(1) > IW'(C - 1)) ? XW'(C - 1) : XW'(qi[k] + IW'(1));
            end
        end
    endgenerate

    always_comb
    begin
        if (state_reg == S_IDLE)
        begin
            p_sel[0] = q_cmd.x;
            p_sel[1] = q_cmd.y;
            p_sel[2] = q_cmd.z;
        end
        else
        begin
            p_sel[0] = pos_rd[0];
            p_sel[1] = pos_rd[1];
            p_sel[2] = pos_rd[2];
        end
    end

    assign cell_new = cell_of(clampi[0], clampi[1], clampi[2]);
    assign cell_cur = cell_of(x_reg, y_reg, z_reg);
    assign d2 = DIST_W'(sq_reg[0]) + DIST_W'(sq_reg[1]) + DIST_W'(sq_reg[2]);

    assign q_pop = (state_reg == S_IDLE) && q_valid && !out_valid_reg;

    always_comb
    begin
        div_start   = 1'b0;
        pos_raddr   = idx_reg[AW-1:0];
        pos_we      = 1'b0;
        acell_we    = 1'b0;
        cnt_we      = 1'b0;
        cnt_waddr   = cell_reg;
        cnt_wdata   = cnt_rd + 1'b1;
        cnt_raddr   = cell_new;
        first_we    = 1'b0;
        first_waddr = cc_reg;
        first_raddr = CELLW'(cell_cur);
        ord_we      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                div_start = q_pop && (q_cmd.op == OP_QUERY) && ready_reg
                            && (total_reg != '0);
            end
            S_LOAD:
            begin
                pos_we = (total_reg != CNTW'(MAX_ATOMS));
            end
            S_CNT_DIV:
            begin
                div_start = 1'b1;
            end
            S_CNT_WAIT:
            begin
                acell_we = &div_done;
            end
            S_CNT_INC:
            begin
                cnt_we = 1'b1;
            end
            S_ZERO:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = cc_reg[CIDW-1:0];
                cnt_wdata = '0;
            end
            S_PRE_RD:
            begin
                cnt_raddr = cc_reg[CIDW-1:0];
                first_we  = (cc_reg == CELLW'(NCELLS));
            end
            S_PRE_WR:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = cc_reg[CIDW-1:0];
                cnt_wdata = run_reg;
                first_we  = 1'b1;
            end
            S_PL_CUR:
            begin
                cnt_raddr = acell_rd;
            end
            S_PL_WR:
            begin
                cnt_we = 1'b1;
                ord_we = 1'b1;
            end
            S_Q_C1:
            begin
                first_raddr = CELLW'(cell_cur) + 1'b1;
            end
            S_Q_S1:
            begin
                pos_raddr = ord_rd;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pos_we)
        begin
            posx_mem[total_reg[AW-1:0]] <= cmd_reg.x;
            posy_mem[total_reg[AW-1:0]] <= cmd_reg.y;
            posz_mem[total_reg[AW-1:0]] <= cmd_reg.z;
            val_mem[total_reg[AW-1:0]]  <= scaled;
        end
        pos_rd[0] <= posx_mem[pos_raddr];
        pos_rd[1] <= posy_mem[pos_raddr];
        pos_rd[2] <= posz_mem[pos_raddr];
        val_rd    <= val_mem[pos_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (acell_we)
            acell_mem[idx_reg[AW-1:0]] <= cell_new;
        acell_rd <= acell_mem[idx_reg[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
            cnt_mem[cnt_waddr] <= cnt_wdata;
        cnt_rd <= cnt_mem[cnt_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (first_we)
            first_mem[first_waddr] <= run_reg;
        first_rd <= first_mem[first_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ord_we)
            ord_mem[cnt_rd[AW-1:0]] <= idx_reg[AW-1:0];
        ord_rd <= ord_mem[slot_reg[AW-1:0]];
    end

    assign res.valid         = out_valid_reg;
    assign res.status        = out_status_reg;
    assign res.nearest_value = out_value_reg;
    assign res.color_red     = out_rgb_reg.r;
    assign res.color_green   = out_rgb_reg.g;
    assign res.color_blue    = out_rgb_reg.b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            total_reg     <= '0;
            ready_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                lo_reg[i]   <= '0;
                hi_reg[i]   <= '0;
                span_reg[i] <= '0;
                neg_reg[i]  <= 1'b0;
            end
        end
        else
        begin
            if (res.valid && res.ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_pop)
                    begin
                        cmd_reg    <= q_cmd;
                        status_reg <= 1'b0;
                        bestv_reg  <= '0;
                        bestd_reg  <= LIMIT_SQ;
                        idx_reg    <= '0;
                        for (int i = 0; i < 3; i++)
                            neg_reg[i] <= nsign[i];
                        unique case (q_cmd.op)
                            OP_CLEAR:
                            begin
                                total_reg <= '0;
                                ready_reg <= 1'b0;
                                for (int i = 0; i < 3; i++)
                                begin
                                    lo_reg[i] <= '0;
                                    hi_reg[i] <= '0;
                                end
                                state_reg <= S_FIN;
                            end
                            OP_LOAD:
                                state_reg <= S_LOAD;
                            OP_BUILD:
                                state_reg <= S_BOX_RD;
                            OP_QUERY:
                                state_reg <= div_start ? S_Q_DIV : S_FIN;
                            default:
                                state_reg <= S_FIN;
                        endcase
                    end
                end
                S_LOAD:
                begin
                    if (total_reg == CNTW'(MAX_ATOMS))
                        status_reg <= 1'b1;
                    else
                    begin
                        total_reg <= total_reg + 1'b1;
                        ready_reg <= 1'b0;
                    end
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    out_valid_reg  <= 1'b1;
                    out_status_reg <= status_reg;
                    out_value_reg  <= bestv_reg;
                    out_rgb_reg    <= (cmd_reg.op == OP_QUERY) ? color_of(bestv_reg)
                                                               : rgb_t'('0);
                    state_reg      <= S_IDLE;
                end
                S_BOX_RD:
                    state_reg <= (idx_reg == total_reg) ? S_BOUND : S_BOX_ACC;
                S_BOX_ACC:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        if (idx_reg == '0 || pos_rd[i] < mn_reg[i])
                            mn_reg[i] <= pos_rd[i];
                        if (idx_reg == '0 || pos_rd[i] > mx_reg[i])
                            mx_reg[i] <= pos_rd[i];
                    end
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= S_BOX_RD;
                end
                S_BOUND:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        if (total_reg == '0)
                        begin
                            lo_reg[i]   <= '0;
                            hi_reg[i]   <= '0;
                            span_reg[i] <= '0;
                        end
                        else
                        begin
                            lo_reg[i]   <= BOUND_W'(mn_reg[i]) - 1'b1;
                            hi_reg[i]   <= BOUND_W'(mx_reg[i]) + 1'b1;
                            span_reg[i] <= DW'(DW'(mx_reg[i]) - DW'(mn_reg[i]) + DW'(2));
                        end
                    end
                    cc_reg    <= '0;
                    state_reg <= S_ZERO;
                end
                S_ZERO:
                begin
                    cc_reg <= cc_reg + 1'b1;
                    if (cc_reg == CELLW'(NCELLS - 1))
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_CNT_RD;
                    end
                end
                S_CNT_RD:
                begin
                    if (idx_reg == total_reg)
                    begin
                        cc_reg    <= '0;
                        run_reg   <= '0;
                        state_reg <= S_PRE_RD;
                    end
                    else
                        state_reg <= S_CNT_DIV;
                end
                S_CNT_DIV:
                begin
                    for (int i = 0; i < 3; i++)
                        neg_reg[i] <= nsign[i];
                    state_reg <= S_CNT_WAIT;
                end
                S_CNT_WAIT:
                begin
                    if (&div_done)
                    begin
                        cell_reg  <= cell_new;
                        state_reg <= S_CNT_INC;
                    end
                end
                S_CNT_INC:
                begin
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= S_CNT_RD;
                end
                S_PRE_RD:
                begin
                    if (cc_reg == CELLW'(NCELLS))
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_PL_RD;
                    end
                    else
                        state_reg <= S_PRE_WR;
                end
                S_PRE_WR:
                begin
                    run_reg   <= run_reg + cnt_rd;
                    cc_reg    <= cc_reg + 1'b1;
                    state_reg <= S_PRE_RD;
                end
                S_PL_RD:
                begin
                    if (idx_reg == total_reg)
                    begin
                        ready_reg <= 1'b1;
                        state_reg <= S_FIN;
                    end
                    else
                        state_reg <= S_PL_CUR;
                end
                S_PL_CUR:
                begin
                    cell_reg  <= acell_rd;
                    state_reg <= S_PL_WR;
                end
                S_PL_WR:
                begin
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= S_PL_RD;
                end
                S_Q_DIV:
                begin
                    if (&div_done)
                    begin
                        if (|rempty)
                            state_reg <= S_FIN;
                        else
                        begin
                            x_reg  <= rs[0];
                            y_reg  <= rs[1];
                            z_reg  <= rs[2];
                            ys_reg <= rs[1];
                            zs_reg <= rs[2];
                            xe_reg <= re[0];
                            ye_reg <= re[1];
                            ze_reg <= re[2];
                            state_reg <= S_Q_C0;
                        end
                    end
                end
                S_Q_C0:
                    state_reg <= S_Q_C1;
                S_Q_C1:
                begin
                    slot_reg  <= first_rd;
                    state_reg <= S_Q_C2;
                end
                S_Q_C2:
                begin
                    slot_end_reg <= first_rd;
                    state_reg    <= S_Q_S0;
                end
                S_Q_S0:
                begin
                    if (slot_reg != slot_end_reg)
                        state_reg <= S_Q_S1;
                    else if (z_reg != ze_reg)
                    begin
                        z_reg     <= z_reg + 1'b1;
                        state_reg <= S_Q_C0;
                    end
                    else if (y_reg != ye_reg)
                    begin
                        y_reg     <= y_reg + 1'b1;
                        z_reg     <= zs_reg;
                        state_reg <= S_Q_C0;
                    end
                    else if (x_reg != xe_reg)
                    begin
                        x_reg     <= x_reg + 1'b1;
                        y_reg     <= ys_reg;
                        z_reg     <= zs_reg;
                        state_reg <= S_Q_C0;
                    end
                    else
                        state_reg <= S_FIN;
                end
                S_Q_S1:
                    state_reg <= S_Q_S2;
                S_Q_S2:
                begin
                    sq_reg[0] <= 50'($signed(BOUND_W'(cmd_reg.x) - BOUND_W'(pos_rd[0]))
                                   * $signed(BOUND_W'(cmd_reg.x) - BOUND_W'(pos_rd[0])));
                    sq_reg[1] <= 50'($signed(BOUND_W'(cmd_reg.y) - BOUND_W'(pos_rd[1]))
                                   * $signed(BOUND_W'(cmd_reg.y) - BOUND_W'(pos_rd[1])));
                    sq_reg[2] <= 50'($signed(BOUND_W'(cmd_reg.z) - BOUND_W'(pos_rd[2]))
                                   * $signed(BOUND_W'(cmd_reg.z) - BOUND_W'(pos_rd[2])));
                    cand_reg  <= val_rd;
                    state_reg <= S_Q_S3;
                end
                S_Q_S3:
                begin
                    if (d2 < bestd_reg)
                    begin
                        bestd_reg <= d2;
                        bestv_reg <= cand_reg;
                    end
                    slot_reg  <= slot_reg + 1'b1;
                    state_reg <= S_Q_S0;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

/* design/grid_nearest_atom_color.sv */
// nearest-atom colouring over a uniform 3d grid
// cmd channel: opcode 0 clears the store, 1 loads an atom (value scaled by 1/7),
// 2 builds the grid, 3 queries a vertex; coordinates are signed Q13.10
// res channel: one beat per command; status flags a load dropped on a full
// store, nearest_value and the rgb colour carry the query answer (zero otherwise)
// a two-entry command queue takes beats while the result register waits
// once a command leaves the queue, a query runs the three cell-index dividers
// and then scans the cells and atoms of the 3x3x3 neighborhood (single read
// port on the atom memories)
// build walks the atoms for the bounding box, zeroes the CELLS_PER_AXIS^3
// cell counts, bins each atom through the dividers, forms the prefix sum
// over the cells and then places the atoms
// reset empties the store and marks the grid not built; memories need no clearing
// when res is stalled the held beat stays and at most two commands queue up
module grid_nearest_atom_color #(
    parameter int MAX_ATOMS      = 1024,
    parameter int CELLS_PER_AXIS = 8
) (
    input logic        clk,
    input logic        rst_n,
    gnac_cmd_if.sink   cmd,
    gnac_res_if.source res
);
    import gnac_pkg::*;

    logic q_valid;
    logic q_pop;
    cmd_t q_cmd;

    gnac_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop)
    );

    gnac_back #(
        .MAX_ATOMS      (MAX_ATOMS),
        .CELLS_PER_AXIS (CELLS_PER_AXIS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop),
        .res     (res)
    );

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import gnac_pkg::*;

    localparam int STORE_DEPTH = 1024;
    localparam int AXIS_CELLS  = 8;
    localparam int CELL_COUNT  = AXIS_CELLS * AXIS_CELLS * AXIS_CELLS;
    localparam int RANDOM_ITEMS = 470;

    typedef struct {
        logic               status;
        logic signed [19:0] value;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
    } answer_t;

    logic clk;
    logic rst_n;

    gnac_cmd_if cmd ();
    gnac_res_if res ();

    grid_nearest_atom_color u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd.sink),
        .res   (res.source)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    cmd_t    pending_cmds[$];
    answer_t expected_answers[$];
    int      total_cmds;
    int      sent_cmds;
    int      mismatches;

    // shadow of the atom store and grid
    longint  atom_x[STORE_DEPTH];
    longint  atom_y[STORE_DEPTH];
    longint  atom_z[STORE_DEPTH];
    longint  atom_val[STORE_DEPTH];
    int      atom_count;
    longint  box_lo[3];
    longint  box_hi[3];
    int      cell_start[CELL_COUNT + 1];
    int      cell_atom[STORE_DEPTH];
    bit      grid_built;

    function automatic longint axis_index(longint p, int k);
        longint span;
        begin
            span = box_hi[k] - box_lo[k];
            if (span <= 0)
                return -1000;
            return ((p - box_lo[k]) * AXIS_CELLS) / span;
        end
    endfunction

    function automatic int clip_axis(longint i);
        begin
            if (i < 0)
                return 0;
            if (i > AXIS_CELLS - 1)
                return AXIS_CELLS - 1;
            return int'(i);
        end
    endfunction

    function automatic int home_cell(int a);
        begin
            return (clip_axis(axis_index(atom_x[a], 0)) * AXIS_CELLS
                    + clip_axis(axis_index(atom_y[a], 1))) * AXIS_CELLS
                    + clip_axis(axis_index(atom_z[a], 2));
        end
    endfunction

    function automatic void bin_atoms();
        int fill[CELL_COUNT];
        int run;
        int c;
        begin
            if (atom_count == 0)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    box_lo[k] = 0;
                    box_hi[k] = 0;
                end
            end
            else
            begin
                box_lo[0] = atom_x[0]; box_hi[0] = atom_x[0];
                box_lo[1] = atom_y[0]; box_hi[1] = atom_y[0];
                box_lo[2] = atom_z[0]; box_hi[2] = atom_z[0];
                for (int a = 1; a < atom_count; a++)
                begin
                    if (atom_x[a] < box_lo[0]) box_lo[0] = atom_x[a];
                    if (atom_x[a] > box_hi[0]) box_hi[0] = atom_x[a];
                    if (atom_y[a] < box_lo[1]) box_lo[1] = atom_y[a];
                    if (atom_y[a] > box_hi[1]) box_hi[1] = atom_y[a];
                    if (atom_z[a] < box_lo[2]) box_lo[2] = atom_z[a];
                    if (atom_z[a] > box_hi[2]) box_hi[2] = atom_z[a];
                end
                for (int k = 0; k < 3; k++)
                begin
                    box_lo[k] = box_lo[k] - 1;
                    box_hi[k] = box_hi[k] + 1;
                end
            end
            for (int i = 0; i < CELL_COUNT; i++)
                fill[i] = 0;
            for (int a = 0; a < atom_count; a++)
                fill[home_cell(a)]++;
            run = 0;
            for (int i = 0; i < CELL_COUNT; i++)
            begin
                cell_start[i] = run;
                run = run + fill[i];
                fill[i] = cell_start[i];
            end
            cell_start[CELL_COUNT] = run;
            for (int a = 0; a < atom_count; a++)
            begin
                c = home_cell(a);
                cell_atom[fill[c]] = a;
                fill[c]++;
            end
            grid_built = 1'b1;
        end
    endfunction

    function automatic longint nearest_atom_value(longint px, longint py, longint pz);
        longint best;
        longint found;
        longint ix;
        longint iy;
        longint iz;
        longint dx;
        longint dy;
        longint dz;
        longint d2;
        int     c;
        int     a;
        begin
            best  = 64'sd104857600000000;
            found = 0;
            if (!grid_built || atom_count == 0)
                return 0;
            ix = axis_index(px, 0);
            iy = axis_index(py, 1);
            iz = axis_index(pz, 2);
            for (longint x = (ix > 1 ? ix - 1 : 0); x <= ix + 1 && x < AXIS_CELLS; x++)
                for (longint y = (iy > 1 ? iy - 1 : 0); y <= iy + 1 && y < AXIS_CELLS; y++)
                    for (longint z = (iz > 1 ? iz - 1 : 0); z <= iz + 1 && z < AXIS_CELLS; z++)
                    begin
                        c = int'((x * AXIS_CELLS + y) * AXIS_CELLS + z);
                        for (int s = cell_start[c]; s < cell_start[c + 1]; s++)
                        begin
                            a  = cell_atom[s];
                            dx = px - atom_x[a];
                            dy = py - atom_y[a];
                            dz = pz - atom_z[a];
                            d2 = dx * dx + dy * dy + dz * dz;
                            if (d2 < best)
                            begin
                                best  = d2;
                                found = atom_val[a];
                            end
                        end
                    end
            return found;
        end
    endfunction

    function automatic logic [7:0] shade(longint c);
        longint t;
        begin
            t = c < 0 ? 0 : (c > 4096 ? 4096 : c);
            return 8'((t * 255 + 2048) >>> 12);
        end
    endfunction

    function automatic answer_t apply_cmd(cmd_t c);
        answer_t r;
        longint  v;
        begin
            r = '{1'b0, 20'sd0, 8'd0, 8'd0, 8'd0};
            case (c.op)
                OP_CLEAR:
                begin
                    atom_count = 0;
                    grid_built = 1'b0;
                    for (int k = 0; k < 3; k++)
                    begin
                        box_lo[k] = 0;
                        box_hi[k] = 0;
                    end
                end
                OP_LOAD:
                begin
                    if (atom_count >= STORE_DEPTH)
                        r.status = 1'b1;
                    else
                    begin
                        atom_x[atom_count]   = longint'(c.x);
                        atom_y[atom_count]   = longint'(c.y);
                        atom_z[atom_count]   = longint'(c.z);
                        atom_val[atom_count] = longint'(c.val) / 7;
                        atom_count++;
                        grid_built = 1'b0;
                    end
                end
                OP_BUILD:
                    bin_atoms();
                default:
                begin
                    v = nearest_atom_value(longint'(c.x), longint'(c.y), longint'(c.z));
                    r.value = 20'(v);
                    if (v < 0)
                    begin
                        r.blue  = 8'd255;
                        r.red   = shade(4096 + v);
                        r.green = r.red;
                    end
                    else if (v > 0)
                    begin
                        r.red   = 8'd255;
                        r.green = shade(4096 - v);
                        r.blue  = r.green;
                    end
                    else
                    begin
                        r.red   = 8'd255;
                        r.green = 8'd255;
                        r.blue  = 8'd255;
                    end
                end
            endcase
            return r;
        end
    endfunction

    // stimulus helpers
    int gen_x[$];
    int gen_y[$];
    int gen_z[$];

    function automatic void push_cmd(op_t o, int x, int y, int z, int v);
        cmd_t c;
        begin
            c.op  = o;
            c.x   = 24'(x);
            c.y   = 24'(y);
            c.z   = 24'(z);
            c.val = 20'(v);
            pending_cmds.insert(pending_cmds.size(), c);
        end
    endfunction

    function automatic int rand_coord();
        return int'($urandom) >>> 8;
    endfunction

    function automatic int rand_value();
        case ($urandom_range(0, 5))
            0: return -524288;
            1: return 524287;
            2: return 0;
            3: return $urandom_range(0, 40) - 20;
            default: return int'($urandom) >>> 12;
        endcase
    endfunction

    function automatic int sat24(longint v);
        return int'(v > 8388607 ? 8388607 : (v < -8388608 ? -8388608 : v));
    endfunction

    function automatic void load_atom(int x, int y, int z, int v);
        begin
            push_cmd(OP_LOAD, x, y, z, v);
            gen_x.insert(gen_x.size(), x);
            gen_y.insert(gen_y.size(), y);
            gen_z.insert(gen_z.size(), z);
        end
    endfunction

    function automatic void query_somewhere(int spread);
        int i;
        begin
            if (gen_x.size() > 0 && $urandom_range(0, 3) != 0)
            begin
                i = $urandom_range(0, gen_x.size() - 1);
                if ($urandom_range(0, 2) == 0)
                    push_cmd(OP_QUERY, gen_x[i], gen_y[i], gen_z[i], rand_value());
                else
                    push_cmd(OP_QUERY,
                             sat24(longint'(gen_x[i]) + $urandom_range(0, 2 * spread) - spread),
                             sat24(longint'(gen_y[i]) + $urandom_range(0, 2 * spread) - spread),
                             sat24(longint'(gen_z[i]) + $urandom_range(0, 2 * spread) - spread),
                             rand_value());
            end
            else
                push_cmd(OP_QUERY, rand_coord(), rand_coord(), rand_coord(), rand_value());
        end
    endfunction

    initial
    begin
        int n;
        int spread;
        int cx;
        int cy;
        int cz;
        int before_count;

        // query and build on an empty store
        push_cmd(OP_QUERY, 0, 0, 0, 0);
        push_cmd(OP_BUILD, 0, 0, 0, 0);
        push_cmd(OP_QUERY, 5, -5, 0, 0);
        // extremes of position and value, duplicates for ties
        load_atom(-8388608, -8388608, -8388608, -524288);
        load_atom(8388607, 8388607, 8388607, 524287);
        load_atom(1000, 2000, 3000, 7);
        load_atom(1000, 2000, 3000, -7);
        load_atom(0, 0, 0, 0);
        load_atom(-1000, 500, 20, -6);
        push_cmd(OP_QUERY, 1000, 2000, 3000, 0);
        push_cmd(OP_BUILD, 0, 0, 0, 0);
        push_cmd(OP_QUERY, 1000, 2000, 3000, 0);
        push_cmd(OP_QUERY, -8388608, -8388608, -8388608, 0);
        push_cmd(OP_QUERY, 8388607, 8388607, 8388607, 0);
        push_cmd(OP_QUERY, 8388607, -8388608, 0, 0);
        push_cmd(OP_QUERY, 1, 1, 1, 0);
        push_cmd(OP_QUERY, -1000, 500, 19, 0);
        // load after build drops the grid
        load_atom(-900, 400, 10, 524287);
        push_cmd(OP_QUERY, -900, 400, 10, 0);
        push_cmd(OP_BUILD, 0, 0, 0, 0);
        push_cmd(OP_QUERY, -900, 400, 10, 0);
        // vertex well outside a small box
        push_cmd(OP_CLEAR, 0, 0, 0, 0);
        gen_x.delete(); gen_y.delete(); gen_z.delete();
        load_atom(100, 100, 100, 3000);
        load_atom(200, 200, 200, -3000);
        push_cmd(OP_BUILD, 0, 0, 0, 0);
        push_cmd(OP_QUERY, 5000, 5000, 5000, 0);
        push_cmd(OP_QUERY, 150, 150, 150, 0);
        push_cmd(OP_QUERY, 0, 0, 0, 0);
        push_cmd(OP_CLEAR, 0, 0, 0, 0);
        gen_x.delete(); gen_y.delete(); gen_z.delete();

        before_count = pending_cmds.size();
        while (pending_cmds.size() - before_count < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0: push_cmd(op_t'($urandom_range(0, 3)), rand_coord(), rand_coord(),
                            rand_coord(), rand_value());
                default:
                begin
                    if ($urandom_range(0, 4) != 0)
                    begin
                        push_cmd(OP_CLEAR, rand_coord(), rand_coord(), rand_coord(),
                                 rand_value());
                        gen_x.delete(); gen_y.delete(); gen_z.delete();
                    end
                    n = $urandom_range(0, 30);
                    spread = $urandom_range(0, 2) == 0 ? 8388607 : $urandom_range(1, 50000);
                    cx = rand_coord();
                    cy = rand_coord();
                    cz = rand_coord();
                    for (int i = 0; i < n; i++)
                    begin
                        if (gen_x.size() > 0 && $urandom_range(0, 7) == 0)
                            load_atom(gen_x[0], gen_y[0], gen_z[0], rand_value());
                        else
                            load_atom(
                                sat24(longint'(cx) + $urandom_range(0, 2 * spread) - spread),
                                sat24(longint'(cy) + $urandom_range(0, 2 * spread) - spread),
                                sat24(longint'(cz) + $urandom_range(0, 2 * spread) - spread),
                                rand_value());
                    end
                    if ($urandom_range(0, 9) != 0)
                        push_cmd(OP_BUILD, rand_coord(), rand_coord(), rand_coord(),
                                 rand_value());
                    if ($urandom_range(0, 5) == 0)
                        load_atom(cx, cy, cz, rand_value());
                    n = $urandom_range(3, 12);
                    for (int i = 0; i < n; i++)
                        query_somewhere(spread);
                end
            endcase
        end
        total_cmds = pending_cmds.size();
    end

    function automatic int idle_pct(bit sender);
        begin
            case ((sent_cmds * 5 / (total_cmds + 1)) % 4)
                0: return 0;
                1: return sender ? 49 : 0;
                2: return sender ? 0 : 49;
                default: return 29;
            endcase
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd.valid      <= 1'b0;
            cmd.opcode     <= OP_CLEAR;
            cmd.coord_x    <= '0;
            cmd.coord_y    <= '0;
            cmd.coord_z    <= '0;
            cmd.atom_value <= '0;
        end
        else if (!cmd.valid || cmd.ready)
        begin
            if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= idle_pct(1'b1))
            begin
                cmd_t c;
                c = pending_cmds.pop_front();
                expected_answers.insert(expected_answers.size(), apply_cmd(c));
                sent_cmds++;
                cmd.valid      <= 1'b1;
                cmd.opcode     <= c.op;
                cmd.coord_x    <= c.x;
                cmd.coord_y    <= c.y;
                cmd.coord_z    <= c.z;
                cmd.atom_value <= c.val;
            end
            else
                cmd.valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res.ready <= 1'b0;
        else
        begin
            if (res.valid && res.ready)
            begin
                answer_t e;
                if (expected_answers.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: status %0d value %0d rgb %0d %0d %0d",
                                 res.status, res.nearest_value, res.color_red,
                                 res.color_green, res.color_blue);
                end
                else
                begin
                    e = expected_answers.pop_front();
                    if (res.status !== e.status || res.nearest_value !== e.value
                        || res.color_red !== e.red || res.color_green !== e.green
                        || res.color_blue !== e.blue)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("mismatch: expected status %0d value %0d rgb %0d %0d %0d",
                                     e.status, e.value, e.red, e.green, e.blue);
                            $display("          got status %0d value %0d rgb %0d %0d %0d",
                                     res.status, res.nearest_value, res.color_red,
                                     res.color_green, res.color_blue);
                        end
                    end
                end
            end
            res.ready <= $urandom_range(0, 99) >= idle_pct(1'b0);
        end
    end

    initial
    begin
        atom_count = 0;
        grid_built = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            box_lo[k] = 0;
            box_hi[k] = 0;
        end
        sent_cmds  = 0;
        mismatches = 0;
        rst_n      = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        wait (total_cmds > 0);
        while (pending_cmds.size() > 0 || cmd.valid || expected_answers.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatches == 0 && expected_answers.size() == 0)
            $display("grid_nearest_atom_color regression: pass");
        else
            $display("grid_nearest_atom_color regression: fail");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("grid_nearest_atom_color regression: fail");
        $finish;
    end

endmodule
